@@ rtl/ctp_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types, constants and arithmetic helpers for the Cassini torus point pipeline.
package ctp_pkg;

    typedef struct packed {
        logic [15:0] angle_u;
        logic [15:0] angle_v;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               invalid;
    } out_t;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_RING_RADIUS = 2'd0;
    localparam logic [1:0] REG_OVAL_A      = 2'd1;
    localparam logic [1:0] REG_OVAL_B      = 2'd2;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] SIN_C9  = 31'd172272;

    typedef logic [30:0] coef_arr_t [4];
    localparam coef_arr_t SIN_COEF = '{31'd5026995, 31'd85569306, 31'd693598668,
                                       31'd1686629713};

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sqrt_pair_t;

    function automatic sqrt_pair_t sqrt_step(input sqrt_pair_t p, input logic [63:0] bit_v);
        sqrt_pair_t  q;
        logic [63:0] trial;
        trial = p.res + bit_v;
        if (p.n >= trial) begin
            q.n   = p.n - trial;
            q.res = (p.res >> 1) + bit_v;
        end else begin
            q.n   = p.n;
            q.res = p.res >> 1;
        end
        return q;
    endfunction

    function automatic logic signed [33:0] mul_q30(input logic signed [32:0] v,
                                                   input logic signed [31:0] s);
        logic        neg;
        logic [31:0] mv;
        logic [30:0] ms;
        logic [62:0] prod;
        logic [62:0] rnd;
        logic [32:0] r;
        neg  = v[32] ^ s[31];
        mv   = v[32] ? 32'(-v) : v[31:0];
        ms   = s[31] ? 31'(-s) : s[30:0];
        prod = mv * ms;
        rnd  = prod + 63'h2000_0000;
        r    = rnd[62:30];
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

endpackage

@@ rtl/cassinian_torus_point.sv @@
`timescale 1ns / 1ps
// Cassini oval torus point evaluator: top level with trig lanes and the arithmetic pipeline.
// Each input transaction on s_ carries two angles u and v; each one yields exactly one
// output transaction on m_ with the point (x, y, z) in signed Q16.16 and an invalid flag.
// The invalid flag is set, and the coordinates are zero, when a square root argument is
// negative. Ring radius and oval constants a and b are written over the APB port; the user
// must write them only while no transaction is in flight, as the block itself does not
// enforce it. pready is always high and reads return the stored values. The pipeline is
// 45 stages deep. Throughput is one transaction per cycle unless the receiver stalls;
// the slowest stage holds a 32 by 32 multiply or two square root steps. When the receiver
// stalls with a result waiting, every stage holds and s_ready drops in the same cycle, so
// nothing is lost or repeated. A synchronous low aresetn clears the valid bits of all
// stages and the configuration registers to zero.
module cassinian_torus_point #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ctp_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ctp_pkg::out_t               m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ctp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int NLANE   = 6;
    localparam int SIN_LAT = 6;
    localparam int D_PS    = 7;
    localparam int D_RAD   = 9;
    localparam int D_S     = 25;
    localparam int D_E     = 26;
    localparam int D_M     = 42;
    localparam int D_MC    = 43;
    localparam int D_R     = 44;
    localparam int D_OUT   = 45;

    localparam int LANE_SIN2V = 0;
    localparam int LANE_COS2V = 1;
    localparam int LANE_SINV  = 2;
    localparam int LANE_COSV  = 3;
    localparam int LANE_SINU  = 4;
    localparam int LANE_COSU  = 5;

    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int          PH_SHIFT   = 32 - ANGLE_BITS;
    localparam logic [31:0] QUARTER    = 32'h4000_0000;

    typedef struct packed {
        logic [30:0] t;
        logic [30:0] t2;
        logic [30:0] acc;
        logic        neg;
    } sine_stage_t;

    typedef struct packed {
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_u;
        logic signed [31:0] cos_u;
        logic signed [33:0] ac;
        logic               bad;
        logic signed [33:0] y;
    } side_t;

    logic [15:0] ring_radius_reg;
    logic [15:0] oval_a_reg;
    logic [15:0] oval_b_reg;
    logic [31:0] a2_reg;
    logic [31:0] b2_reg;
    logic [63:0] b4_reg;

    logic              en;
    logic [D_OUT:1]    vld_reg;
    logic [31:0]       pu;
    logic [31:0]       pv;
    logic [31:0]       p2v;
    logic [31:0]       lane_ph [NLANE];
    sine_stage_t       sn_reg [NLANE][SIN_LAT-1];
    logic signed [31:0] sin_reg [NLANE];

    side_t              side_reg  [D_PS:D_R];
    side_t              side_next [D_PS:D_R];
    logic signed [32:0] a2s;
    logic signed [33:0] ps_full;
    logic [31:0]        ps_mag_reg;
    logic [63:0]        ps2_reg;
    logic [63:0]        rad_reg;
    logic [31:0]        s_root;
    logic signed [34:0] e_val;
    logic [63:0]        rad2_reg;
    logic [31:0]        m_root;
    logic signed [32:0] m_s;
    logic signed [33:0] y_val;
    logic signed [33:0] mc_reg;
    logic signed [33:0] r_next;
    logic signed [32:0] r_reg;
    logic signed [33:0] x_val;
    logic signed [33:0] z_val;
    ctp_pkg::out_t      out_reg;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_radius_reg <= '0;
            oval_a_reg      <= '0;
            oval_b_reg      <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                ctp_pkg::REG_RING_RADIUS: ring_radius_reg <= pwdata[15:0];
                ctp_pkg::REG_OVAL_A:      oval_a_reg      <= pwdata[15:0];
                ctp_pkg::REG_OVAL_B:      oval_b_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ctp_pkg::REG_RING_RADIUS: prdata = {16'd0, ring_radius_reg};
            ctp_pkg::REG_OVAL_A:      prdata = {16'd0, oval_a_reg};
            ctp_pkg::REG_OVAL_B:      prdata = {16'd0, oval_b_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        a2_reg <= oval_a_reg * oval_a_reg;
        b2_reg <= oval_b_reg * oval_b_reg;
        b4_reg <= b2_reg * b2_reg;
    end

    // Flow control
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[D_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[D_OUT-1:1], s_valid};
        end
    end

    // Sine and cosine lanes
    assign pu  = (32'(s_data.angle_u) & ANGLE_MASK) << PH_SHIFT;
    assign pv  = (32'(s_data.angle_v) & ANGLE_MASK) << PH_SHIFT;
    assign p2v = pv << 1;

    assign lane_ph[LANE_SIN2V] = p2v;
    assign lane_ph[LANE_COS2V] = p2v + QUARTER;
    assign lane_ph[LANE_SINV]  = pv;
    assign lane_ph[LANE_COSV]  = pv + QUARTER;
    assign lane_ph[LANE_SINU]  = pu;
    assign lane_ph[LANE_COSU]  = pu + QUARTER;

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        logic [29:0] frac;
        logic [30:0] t0;
        logic [61:0] tsq;
        logic [61:0] prod_f;
        logic [31:0] mag;
        logic [30:0] magc;

        assign frac = lane_ph[l][29:0];
        assign t0   = lane_ph[l][30] ? (ctp_pkg::Q30_ONE - 31'(frac)) : 31'(frac);
        assign tsq  = t0 * t0;

        always_ff @(posedge aclk) begin
            if (en) begin
                sn_reg[l][0] <= '{t: t0, t2: tsq[60:30], acc: ctp_pkg::SIN_C9,
                                  neg: lane_ph[l][31]};
            end
        end

        for (genvar j = 0; j < 4; j++) begin : g_horner
            logic [61:0] prod;
            logic [30:0] acc_n;

            assign prod  = sn_reg[l][j].acc * sn_reg[l][j].t2;
            assign acc_n = ctp_pkg::SIN_COEF[j] - prod[60:30];

            always_ff @(posedge aclk) begin
                if (en) begin
                    sn_reg[l][j+1] <= '{t: sn_reg[l][j].t, t2: sn_reg[l][j].t2,
                                        acc: acc_n, neg: sn_reg[l][j].neg};
                end
            end
        end

        assign prod_f = sn_reg[l][SIN_LAT-2].acc * sn_reg[l][SIN_LAT-2].t;
        assign mag    = prod_f[61:30];
        assign magc   = (mag > 32'(ctp_pkg::Q30_ONE)) ? ctp_pkg::Q30_ONE : mag[30:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                sin_reg[l] <= sn_reg[l][SIN_LAT-2].neg ? -$signed({1'b0, magc})
                                                       : $signed({1'b0, magc});
            end
        end
    end

    // Oval radius and point arithmetic
    assign a2s     = $signed({1'b0, a2_reg});
    assign ps_full = ctp_pkg::mul_q30(a2s, sin_reg[LANE_SIN2V]);
    assign e_val   = {side_reg[D_S].ac[33], side_reg[D_S].ac} + $signed({3'b0, s_root});
    assign m_s     = $signed({1'b0, m_root});
    assign y_val   = ctp_pkg::mul_q30(m_s, side_reg[D_M].sin_v);
    assign r_next  = $signed({10'd0, ring_radius_reg, 8'd0}) + mc_reg;
    assign x_val   = ctp_pkg::mul_q30(r_reg, side_reg[D_R].cos_u);
    assign z_val   = ctp_pkg::mul_q30(r_reg, side_reg[D_R].sin_u);

    always_comb begin
        side_next[D_PS] = '{sin_v: sin_reg[LANE_SINV], cos_v: sin_reg[LANE_COSV],
                            sin_u: sin_reg[LANE_SINU], cos_u: sin_reg[LANE_COSU],
                            ac: ctp_pkg::mul_q30(a2s, sin_reg[LANE_COS2V]),
                            bad: 1'b0, y: '0};
        for (int k = D_PS + 1; k <= D_R; k++) begin
            side_next[k] = side_reg[k-1];
        end
        side_next[D_RAD].bad = ps2_reg > b4_reg;
        side_next[D_E].bad   = side_reg[D_E-1].bad | e_val[34];
        side_next[D_MC].y    = y_val;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = D_PS; k <= D_R; k++) begin
                side_reg[k] <= side_next[k];
            end
            ps_mag_reg <= ps_full[33] ? 32'(-ps_full) : ps_full[31:0];
            ps2_reg    <= ps_mag_reg * ps_mag_reg;
            rad_reg    <= b4_reg - ps2_reg;
            rad2_reg   <= 64'(e_val[33:0]) << 16;
            mc_reg     <= ctp_pkg::mul_q30(m_s, side_reg[D_M].cos_v);
            r_reg      <= r_next[32:0];
            out_reg.pos_x   <= side_reg[D_R].bad ? 32'sd0 : x_val[31:0];
            out_reg.pos_y   <= side_reg[D_R].bad ? 32'sd0 : side_reg[D_R].y[31:0];
            out_reg.pos_z   <= side_reg[D_R].bad ? 32'sd0 : z_val[31:0];
            out_reg.invalid <= side_reg[D_R].bad;
        end
    end

    ctp_isqrt u_sqrt_s (
        .aclk     (aclk),
        .en       (en),
        .radicand (rad_reg),
        .root     (s_root)
    );

    ctp_isqrt u_sqrt_m (
        .aclk     (aclk),
        .en       (en),
        .radicand (rad2_reg),
        .root     (m_root)
    );

    assign m_data = out_reg;

    // Assertions
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.invalid |->
            m_data.pos_x == 0 && m_data.pos_y == 0 && m_data.pos_z == 0)
        else $error("Invalid point carries nonzero coordinates.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("Pipeline valid bits moved during a stall.");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vld_reg[D_OUT-1]))
        else $error("Output became valid without a transaction in the last stage.");

endmodule

@@ rtl/ctp_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined 64-bit floor square root, two result bits per stage, sixteen stages.
module ctp_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int STAGES = 16;

    ctp_pkg::sqrt_pair_t stage_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        ctp_pkg::sqrt_pair_t src;
        ctp_pkg::sqrt_pair_t mid;
        ctp_pkg::sqrt_pair_t stage_next;

        if (k == 0) begin : g_first
            assign src = '{n: radicand, res: 64'd0};
        end else begin : g_rest
            assign src = stage_reg[k-1];
        end

        assign mid        = ctp_pkg::sqrt_step(src, 64'd1 << (62 - 4 * k));
        assign stage_next = ctp_pkg::sqrt_step(mid, 64'd1 << (60 - 4 * k));

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    assign root = stage_reg[STAGES-1].res[31:0];

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Cassini oval torus point evaluator with random flow control.
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] Q30_UNIT = 64'd1073741824;
    localparam logic [1:0] REG_NONE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ctp_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ctp_pkg::out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ctp_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cassinian_torus_point u_top (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    logic [15:0] radius_q;
    logic [15:0] a_q;
    logic [15:0] b_q;
    ctp_pkg::in_t pending_points[$];
    ctp_pkg::out_t expected_points[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    logic in_taken = 1'b0;

    function automatic logic [63:0] quarter_wave(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] acc;
        t2 = (t * t) >> 30;
        acc = 64'd172272;
        acc = 64'd5026995 - ((acc * t2) >> 30);
        acc = 64'd85569306 - ((acc * t2) >> 30);
        acc = 64'd693598668 - ((acc * t2) >> 30);
        acc = 64'd1686629713 - ((acc * t2) >> 30);
        acc = (acc * t) >> 30;
        if (acc > Q30_UNIT) acc = Q30_UNIT;
        return acc;
    endfunction

    function automatic longint sin_phase(input logic [31:0] ph);
        logic [63:0] frac;
        logic [63:0] t;
        longint s;
        frac = {34'd0, ph[29:0]};
        t = ph[30] ? (Q30_UNIT - frac) : frac;
        s = longint'(quarter_wave(t));
        return ph[31] ? -s : s;
    endfunction

    function automatic longint cos_phase(input logic [31:0] ph);
        return sin_phase(ph + 32'h4000_0000);
    endfunction

    function automatic longint scale_q30(input longint v, input longint s);
        logic neg;
        logic [63:0] mv;
        logic [63:0] ms;
        logic [63:0] r;
        neg = (v < 0) != (s < 0);
        mv = v < 0 ? -v : v;
        ms = s < 0 ? -s : s;
        r = (mv * ms + 64'h2000_0000) >> 30;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic ctp_pkg::out_t torus_point(input ctp_pkg::in_t p);
        ctp_pkg::out_t o;
        logic [31:0] pu;
        logic [31:0] pv;
        logic [31:0] p2v;
        longint a2;
        logic [63:0] b2;
        logic [63:0] b4;
        longint ps;
        logic [63:0] mag;
        logic [63:0] ps2;
        longint s;
        longint e;
        longint m;
        longint r;
        pu = {p.angle_u, 16'd0};
        pv = {p.angle_v, 16'd0};
        p2v = pv << 1;
        a2 = longint'({48'd0, a_q}) * longint'({48'd0, a_q});
        b2 = {48'd0, b_q} * {48'd0, b_q};
        b4 = b2 * b2;
        ps = scale_q30(a2, sin_phase(p2v));
        mag = ps < 0 ? -ps : ps;
        ps2 = mag * mag;
        o = '0;
        o.invalid = 1'b1;
        if (ps2 <= b4) begin
            s = longint'(floor_sqrt(b4 - ps2));
            e = scale_q30(a2, cos_phase(p2v)) + s;
            if (e >= 0) begin
                m = longint'(floor_sqrt(64'(e) << 16));
                o.pos_y = 32'(scale_q30(m, sin_phase(pv)));
                r = longint'({48'd0, radius_q} << 8) + scale_q30(m, cos_phase(pv));
                o.pos_x = 32'(scale_q30(r, cos_phase(pu)));
                o.pos_z = 32'(scale_q30(r, sin_phase(pu)));
                o.invalid = 1'b0;
            end
        end
        return o;
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ctp_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == ctp_pkg::REG_RING_RADIUS) radius_q = val[15:0];
        else if (idx == ctp_pkg::REG_OVAL_A) a_q = val[15:0];
        else if (idx == ctp_pkg::REG_OVAL_B) b_q = val[15:0];
    endtask

    task automatic load_shape(input logic [15:0] rr, input logic [15:0] aa,
                              input logic [15:0] bb);
        apb_write(ctp_pkg::REG_RING_RADIUS, {$urandom} << 16 | rr);
        apb_write(ctp_pkg::REG_OVAL_A, {16'hffff, aa});
        apb_write(ctp_pkg::REG_OVAL_B, {16'h0, bb});
        apb_write(REG_NONE, $urandom);
    endtask

    task automatic drain();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_points.size() != 0 || expected_points.size() != 0 || s_valid);
        repeat (2) @(posedge aclk);
    endtask

    task automatic queue_random(input int n);
        ctp_pkg::in_t p;
        repeat (n) begin
            p.angle_u = 16'($urandom);
            p.angle_v = ($urandom_range(0, 3) == 0) ?
                16'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 2) - 1) :
                16'($urandom);
            pending_points.push_back(p);
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    s_data <= pending_points.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin : monitor
        int mism;
        ctp_pkg::out_t want;
        mism = 0;
        if (aresetn) begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                expected_points.push_back(torus_point(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mism = mism + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (m_data.pos_x !== want.pos_x) begin
                        $error("pos_x expected %0d actual %0d", want.pos_x, m_data.pos_x);
                        mism = mism + 1;
                    end
                    if (m_data.pos_y !== want.pos_y) begin
                        $error("pos_y expected %0d actual %0d", want.pos_y, m_data.pos_y);
                        mism = mism + 1;
                    end
                    if (m_data.pos_z !== want.pos_z) begin
                        $error("pos_z expected %0d actual %0d", want.pos_z, m_data.pos_z);
                        mism = mism + 1;
                    end
                    if (m_data.invalid !== want.invalid) begin
                        $error("invalid expected %0b actual %0b", want.invalid, m_data.invalid);
                        mism = mism + 1;
                    end
                end
            end
            errors <= errors + mism;
            idle_cycles <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0
                                                                          : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        ctp_pkg::in_t p;
        radius_q = 0;
        a_q = 0;
        b_q = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // Reset values, then directed corners under a typical shape.
        p = '{angle_u: 16'h1234, angle_v: 16'h2345};
        pending_points.push_back(p);
        drain();
        load_shape(16'h0300, 16'h0100, 16'h0120);
        for (int i = 0; i < 16; i++) begin
            p.angle_u = 16'd1 << i;
            p.angle_v = ~(16'd1 << i);
            pending_points.push_back(p);
        end
        pending_points.push_back('{angle_u: 16'h0000, angle_v: 16'h0000});
        pending_points.push_back('{angle_u: 16'hffff, angle_v: 16'hffff});
        pending_points.push_back('{angle_u: 16'h4000, angle_v: 16'h2000});
        pending_points.push_back('{angle_u: 16'h8000, angle_v: 16'h6000});
        pending_points.push_back('{angle_u: 16'hc000, angle_v: 16'hc000});
        drain();
        // Lemniscate-like case where b is below a: many points have a negative radicand.
        load_shape(16'h0200, 16'h0180, 16'h0100);
        queue_random(150);
        drain();
        load_shape(16'hffff, 16'hffff, 16'hffff);
        queue_random(150);
        drain();
        load_shape(16'h0000, 16'h0000, 16'hffff);
        queue_random(100);
        drain();
        load_shape(16'hffff, 16'hffff, 16'h0000);
        queue_random(100);
        drain();
        load_shape(16'h0400, 16'h0100, 16'h0100);
        queue_random(150);
        drain();
        repeat (3) begin
            load_shape(16'($urandom), 16'($urandom), 16'($urandom));
            queue_random(120);
            hold_off = 1'b1;
            repeat (200) @(posedge aclk);
            hold_off = 1'b0;
            drain();
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
